[rtl/core/sobel_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the RGB Sobel edge block.
// ----------------------------------------------------------------------------
package sobel_pkg;
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned WIDTH_W = 11;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned ROW_W   = 14;
    localparam int unsigned SQ_W    = 21;
    localparam logic [SQ_W-1:0] SQ_SAT = 21'd65280;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       cmd;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [0:0]          index;
        logic [HEIGHT_W-1:0] data;
    } t_cfg_word;

    // controller -> datapath
    typedef struct packed {
        logic read;      // issue line store read for accepted word
        logic shift;     // write stores, shift window, compute gradient
        logic root_start;
        logic root_step;
        logic load_out;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;       // window center is a valid frame pixel
        logic root_done;
    } t_ctl_stat;
endpackage

[rtl/core/sobel_if.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input, output and configuration words.
// ----------------------------------------------------------------------------
interface sobel_in_if;
    logic                valid;
    logic                ready;
    sobel_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sobel_out_if;
    logic                 valid;
    logic                 ready;
    sobel_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sobel_cfg_if;
    logic                 valid;
    logic                 ready;
    sobel_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sobel_ctrl.sv]
// ----------------------------------------------------------------------------
// Sobel controller
// Sequences read, window update, square root iterations and output load.
// ----------------------------------------------------------------------------
module sobel_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_busy,
    input  sobel_pkg::t_ctl_stat  i_stat,
    output sobel_pkg::t_ctl_cmd   o_cmd
);
    import sobel_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_ROOTI = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.read = 1'b1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = i_stat.emit ? S_ROOTI : S_IDLE;
            end
            S_ROOTI: begin
                o_cmd.root_start = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_read_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> r_state == S_SHIFT) else $error("read not followed by shift");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_state == S_IDLE) else $error("load not followed by idle");
endmodule

[rtl/core/sobel_dp.sv]
// ----------------------------------------------------------------------------
// Sobel datapath
// Line stores, 3x3 window, gradients and an iterative rounded square root.
// ----------------------------------------------------------------------------
module sobel_dp #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sobel_pkg::t_in_word            i_in,
    input  logic [sobel_pkg::WIDTH_W-1:0]  i_width,
    input  logic [sobel_pkg::HEIGHT_W-1:0] i_height,
    input  sobel_pkg::t_ctl_cmd            i_cmd,
    output sobel_pkg::t_ctl_stat           o_stat,
    output sobel_pkg::t_out_word           o_result
);
    import sobel_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EW = (CW > WIDTH_W) ? CW : WIDTH_W;

    // line stores: memory, no reset; a clear sweep runs after reset
    logic [PIX_W-1:0] r_upper [MAX_WIDTH];
    logic [PIX_W-1:0] r_middle[MAX_WIDTH];
    logic [PIX_W-1:0] r_up_q, r_mid_q;
    logic [PIX_W-1:0] r_px;
    logic [PIX_W-1:0] r_win [3][3];
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_addr;
    logic [CW-1:0]    r_cc;
    logic [ROW_W-1:0] r_cr;
    logic             r_emit;

    // effective width/height
    logic [EW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    always_comb begin
        w_eff = EW'(i_width);
        if (i_width == '0) w_eff = EW'(1);
        if (EW'(i_width) > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
        h_eff = (i_height == '0) ? HEIGHT_W'(1) : i_height;
    end

    // position after wrap checks, before this word
    logic [CW-1:0]    pos_col;
    logic [ROW_W-1:0] pos_row;
    logic [CW-1:0]    nxt_col;
    logic [ROW_W-1:0] nxt_row;
    logic             cen_ok;
    logic [ROW_W-1:0] cen_r;
    logic [CW-1:0]    cen_c;
    logic             last;
    always_comb begin
        pos_col = r_col;
        pos_row = r_row;
        if (EW'(pos_col) >= w_eff) begin
            pos_col = '0;
            pos_row = pos_row + ROW_W'(1);
        end
        if (pos_row > ROW_W'(h_eff) + ROW_W'(1)) begin
            pos_row = '0;
            pos_col = '0;
        end
        if (pos_col == '0) begin
            cen_ok = pos_row >= ROW_W'(2);
            cen_r  = pos_row - ROW_W'(2);
            cen_c  = CW'(w_eff - EW'(1));
        end else begin
            cen_ok = pos_row >= ROW_W'(1);
            cen_r  = pos_row - ROW_W'(1);
            cen_c  = pos_col - CW'(1);
        end
        if (cen_ok && cen_r >= ROW_W'(h_eff)) cen_ok = 1'b0;
        nxt_col = pos_col + CW'(1);
        nxt_row = pos_row;
        if (EW'(nxt_col) >= w_eff) begin
            nxt_col = '0;
            nxt_row = pos_row + ROW_W'(1);
        end
        last = cen_ok && (cen_r == ROW_W'(h_eff) - ROW_W'(1))
             && (EW'(cen_c) == w_eff - EW'(1));
    end

    // clear sweep index
    logic [CW-1:0] r_clr;
    logic          clearing;
    assign clearing = (r_clr != CW'(MAX_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (clearing) begin
            r_clr <= r_clr + CW'(1);
        end
    end

    logic [PIX_W-1:0] px_in;
    assign px_in = i_in.cmd ? '0 : {i_in.in_red, i_in.in_green, i_in.in_blue};

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_upper[r_clr[AW-1:0]]  <= '0;
            r_middle[r_clr[AW-1:0]] <= '0;
        end else if (i_cmd.shift) begin
            r_upper[r_addr]  <= r_mid_q;
            r_middle[r_addr] <= r_px;
        end
        if (i_cmd.read) begin
            r_up_q  <= r_upper[pos_col[AW-1:0]];
            r_mid_q <= r_middle[pos_col[AW-1:0]];
            r_addr  <= pos_col[AW-1:0];
            r_px    <= px_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_emit <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) r_win[r][c] <= '0;
        end else begin
            if (i_cmd.read) begin
                r_emit <= cen_ok;
                r_cc   <= cen_c;
                r_cr   <= cen_r;
                if (last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else begin
                    r_col <= nxt_col;
                    r_row <= nxt_row;
                end
            end
            if (i_cmd.shift) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= r_up_q;
                r_win[1][2] <= r_mid_q;
                r_win[2][2] <= r_px;
            end
        end
    end
    assign o_stat.emit = r_emit;

    // masks and per-channel squared magnitude (window registered in shift)
    logic [2:0] rok, cok;
    always_comb begin
        rok[0] = r_cr >= ROW_W'(1);
        rok[1] = 1'b1;
        rok[2] = (r_cr + ROW_W'(1)) < ROW_W'(h_eff);
        cok[0] = r_cc >= CW'(1);
        cok[1] = 1'b1;
        cok[2] = (EW'(r_cc) + EW'(1)) < w_eff;
    end

    logic [SQ_W-1:0] sq [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [11:0] gx, gy;
            logic signed [SQ_W-1:0] gx_w, gy_w;
            logic signed [11:0] v [3][3];
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    v[r][c] = (rok[r] && cok[c])
                        ? $signed({4'b0, r_win[r][c][16-8*ch +: 8]}) : 12'sd0;
            gx = v[0][2] - v[0][0] + 12'sd2 * (v[1][2] - v[1][0]) + v[2][2] - v[2][0];
            gy = v[2][0] - v[0][0] + 12'sd2 * (v[2][1] - v[0][1]) + v[2][2] - v[0][2];
            // widen before squaring so the product keeps all its bits
            gx_w = SQ_W'(gx);
            gy_w = SQ_W'(gy);
            sq[ch] = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);
        end
    end

    // digit-by-digit square root, one result bit per cycle, all channels
    logic [SQ_W-1:0] r_rem [3];
    logic [8:0]      r_q   [3];
    logic [SQ_W-1:0] r_n   [3];
    logic [3:0]      r_it;
    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_it <= 4'd9;
            for (int ch = 0; ch < 3; ch++) begin
                r_n[ch]   <= sq[ch];
                r_rem[ch] <= '0;
                r_q[ch]   <= '0;
            end
        end else if (i_cmd.root_step && r_it != 4'd0) begin
            r_it <= r_it - 4'd1;
            for (int ch = 0; ch < 3; ch++) begin
                logic [SQ_W-1:0] rem2, trial;
                rem2  = {r_rem[ch][SQ_W-3:0], r_n[ch][17:16]};
                trial = {(SQ_W-11)'(0), r_q[ch], 2'b01};
                if (rem2 >= trial) begin
                    r_rem[ch] <= rem2 - trial;
                    r_q[ch]   <= {r_q[ch][7:0], 1'b1};
                end else begin
                    r_rem[ch] <= rem2;
                    r_q[ch]   <= {r_q[ch][7:0], 1'b0};
                end
                r_n[ch] <= {r_n[ch][SQ_W-3:0], 2'b00};
            end
        end
    end
    assign o_stat.root_done = (r_it == 4'd0);

    // round: n > k*k + k  <=>  remainder > k
    logic [7:0] res [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (sq[ch] > SQ_SAT) res[ch] = 8'd255;
            else if (r_rem[ch] > SQ_W'(r_q[ch])) res[ch] = r_q[ch][7:0] + 8'd1;
            else res[ch] = r_q[ch][7:0];
        end
    end

    logic r_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) r_last <= last;
        if (i_cmd.load_out) begin
            o_result.out_red   <= res[0];
            o_result.out_green <= res[1];
            o_result.out_blue  <= res[2];
            o_result.frame_end <= r_last;
        end
    end

    a_emit_inframe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift && r_emit |-> r_cr < ROW_W'(h_eff)) else $error("center row out of frame");
    a_root_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.root_start |=> r_it == 4'd9) else $error("root not started");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |=> EW'(r_col) <= EW'(MAX_WIDTH)) else $error("column overrun");
endmodule

[rtl/core/sobel_edge_magnitude_rgb.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// 3x3 Sobel gradient magnitude per color channel on a raster pixel stream.
// ----------------------------------------------------------------------------
// Each accepted word is read from the line stores and then shifted into the
// window; a word that completes a result also runs the 9-step square root
// iteration and loads the output, waiting while the last result is held;
// only then is a new word taken. Reset: registers go to 640 x 480 and the
// window clears; line stores are then swept clear (words wait; config taken).
module sobel_edge_magnitude_rgb #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sobel_in_if.sink    in_ch,
    sobel_out_if.source out_ch,
    sobel_cfg_if.sink   cfg_ch
);
    import sobel_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                r_out_valid;
    t_ctl_cmd            cmd;
    t_ctl_stat           stat;
    logic                ctl_ready;
    logic                clr_busy;
    logic [$clog2(MAX_WIDTH+1)-1:0] r_sweep;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(640);
            r_height <= HEIGHT_W'(480);
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data.index)
                REG_WIDTH:  r_width  <= cfg_ch.data.data[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= cfg_ch.data.data;
                default: ;
            endcase
        end
    end

    // mirror of datapath clear sweep: hold input while it runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sweep <= '0;
        else if (clr_busy) r_sweep <= r_sweep + ($clog2(MAX_WIDTH+1))'(1);
    end
    assign clr_busy = (r_sweep != ($clog2(MAX_WIDTH+1))'(MAX_WIDTH));

    assign in_ch.ready = ctl_ready && !clr_busy;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid && !clr_busy),
        .o_in_ready (ctl_ready),
        .i_out_busy (r_out_valid && !out_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch.data),
        .i_width  (r_width),
        .i_height (r_height),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (out_ch.data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (cmd.load_out) r_out_valid <= 1'b1;
        else if (out_ch.ready) r_out_valid <= 1'b0;
    end
    assign out_ch.valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(r_out_valid && !out_ch.ready)) else $error("output overwritten");
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !in_ch.ready) else $error("input taken during clear");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data)) else $error("output moved");
endmodule
